[hw/rtl/pll_fractional_param_solver_macros.svh]
// ----------------------------------------------------------------------------
// PLL fractional parameter solver assertion macros
// Short forms for the concurrent checks used in the solver RTL.
// ----------------------------------------------------------------------------
`ifndef PLL_FRACTIONAL_PARAM_SOLVER_MACROS_SVH
`define PLL_FRACTIONAL_PARAM_SOLVER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFPS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pfps: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PFPS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pfps: assertion failed");

`endif

[hw/rtl/pfps_pkg.sv]
// ----------------------------------------------------------------------------
// PLL fractional parameter solver package
// Widths, limits, reset values, codes and shared types of the solver.
// ----------------------------------------------------------------------------
`default_nettype none

package pfps_pkg;

	// Field widths.
	localparam int unsigned REF_W      = 26;
	localparam int unsigned TGT_W      = 32;
	localparam int unsigned DEN_W      = 16;
	localparam int unsigned FRAC_W     = 16;
	localparam int unsigned STATUS_W   = 3;
	localparam int unsigned PREDIV_W   = 5;
	localparam int unsigned INT_W      = 4;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 26;

	// Search limits and the lowest usable integer factor.
	localparam int unsigned PFPS_PD_LIMIT  = 16;
	localparam int unsigned PFPS_MFI_LIMIT = 15;
	localparam int unsigned MFI_FLOOR      = 5;

	// Register reset values.
	localparam logic [REF_W-1:0] RESET_TABLE_REF = REF_W'(24000000);
	localparam logic [DEN_W-1:0] RESET_TABLE_DEN = DEN_W'(24 * 16);

	// Register indexes on the configuration channel.
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_TABLE_REF = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_TABLE_DEN = 1'b1;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_RANGE       = 3'd1,
		ST_UNKNOWN_REF = 3'd2,
		ST_TOO_LARGE   = 3'd3,
		ST_NO_PD       = 3'd4
	} pfps_status_t;

	// Solver sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_SEARCH,
		S_MFI,
		S_MUL,
		S_DIV_F,
		S_GCD,
		S_RED_N,
		S_RED_D,
		S_DONE
	} pfps_state_t;

	// One result item.
	typedef struct packed {
		pfps_status_t        status;
		logic [PREDIV_W-1:0] prediv;
		logic [INT_W-1:0]    int_factor;
		logic [FRAC_W-1:0]   frac_numerator;
		logic [FRAC_W-1:0]   frac_denominator;
	} pfps_res_t;

endpackage

`default_nettype wire

[hw/rtl/pfps_req_if.sv]
// ----------------------------------------------------------------------------
// Solver request channel
// Carries the reference and target frequency of one request transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfps_req_if import pfps_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [REF_W-1:0] ref_hz;
	logic [TGT_W-1:0] target_hz;

	modport source (output valid, output ref_hz, output target_hz, input ready);
	modport sink (input valid, input ref_hz, input target_hz, output ready);
endinterface

`default_nettype wire

[hw/rtl/pfps_rsp_if.sv]
// ----------------------------------------------------------------------------
// Solver response channel
// Carries the status and PLL settings of one response transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfps_rsp_if import pfps_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [PREDIV_W-1:0] prediv;
	logic [INT_W-1:0]    int_factor;
	logic [FRAC_W-1:0]   frac_numerator;
	logic [FRAC_W-1:0]   frac_denominator;

	modport source (
		output valid, output status, output prediv, output int_factor,
		output frac_numerator, output frac_denominator, input ready
	);
	modport sink (
		input valid, input status, input prediv, input int_factor,
		input frac_numerator, input frac_denominator, output ready
	);
endinterface

`default_nettype wire

[hw/rtl/pfps_cfg_if.sv]
// ----------------------------------------------------------------------------
// Solver configuration write channel
// Carries a register index and write data for one write transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfps_cfg_if import pfps_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/pfps_core.sv]
// ----------------------------------------------------------------------------
// PLL fractional parameter solver core
// Sequencer that checks a request, searches the predivider, and computes and
// reduces the fraction on one shared subtractor.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pll_fractional_param_solver_macros.svh"

module pfps_core import pfps_pkg::*; #(
	parameter int unsigned PD_LIMIT  = PFPS_PD_LIMIT,
	parameter int unsigned MFI_LIMIT = PFPS_MFI_LIMIT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [REF_W-1:0] ref_hz,
	input  logic [TGT_W-1:0] target_hz,
	input  logic [REF_W-1:0] table_ref_hz,
	input  logic [DEN_W-1:0] table_denominator,
	output logic             idle,
	output logic             res_valid,
	input  logic             res_ready,
	output pfps_res_t        res
);

	localparam int unsigned PD_W   = $clog2(PD_LIMIT + 1);
	localparam int unsigned MFI_W  = $clog2(MFI_LIMIT + 1);
	localparam int unsigned ACC_W  = TGT_W + PD_W;
	localparam int unsigned A_W    = ACC_W - 2;
	localparam int unsigned SUB_W  = REF_W + MFI_W;
	localparam int unsigned HI_MUL = 4 * MFI_LIMIT;
	localparam int unsigned HI_W   = REF_W + $clog2(HI_MUL + 1);
	localparam int unsigned LO_W   = TGT_W + 1 + PD_W;
	localparam int unsigned CMP_W  = (HI_W > TGT_W) ? HI_W : TGT_W;
	localparam int unsigned PROD_W = REF_W + FRAC_W;
	localparam int unsigned CNT_W  = $clog2(FRAC_W);

	pfps_state_t             state_q, state_d;
	logic [REF_W-1:0]        ref_q, ref_d;
	logic [TGT_W-1:0]        tgt_q, tgt_d;
	logic [PD_W-1:0]         pd_q, pd_d;
	logic [ACC_W-1:0]        acc_q, acc_d;
	logic [MFI_W-1:0]        mfi_q, mfi_d;
	logic [SUB_W-1:0]        rem_q, rem_d;
	logic [FRAC_W-1:0]       dq_q, dq_d;
	logic [REF_W-1:0]        div_q, div_d;
	logic [CNT_W-1:0]        cnt_q, cnt_d;
	logic [DEN_W-1:0]        mfd_q, mfd_d;
	logic [FRAC_W-1:0]       mfn_q, mfn_d;
	logic [FRAC_W-1:0]       ga_q, ga_d;
	logic [FRAC_W-1:0]       gb_q, gb_d;
	logic [SUB_W-1:0]        lim_hi_q, lim_hi_d;
	logic [SUB_W-1:0]        lim_lo_q, lim_lo_d;
	pfps_res_t               res_q, res_d;

	// Shared subtractor with its operand selection.
	logic [SUB_W-1:0]        sub_x, sub_y;
	logic [SUB_W:0]          sub_diff;
	logic                    sub_borrow;
	logic                    gcd_swap;

	// Helper values for the individual steps.
	logic [LO_W-1:0]         ref_x8;
	logic [LO_W-1:0]         tgt_lo;
	logic [HI_W-1:0]         hi_val;
	logic                    range_bad;
	logic [A_W-1:0]          a_val;
	logic [PROD_W-1:0]       prod;
	logic [FRAC_W-1:0]       quot;
	logic                    div_state;

	assign sub_diff   = {1'b0, sub_x} - {1'b0, sub_y};
	assign sub_borrow = sub_diff[SUB_W];
	assign gcd_swap   = gb_q > ga_q;
	assign div_state  = (state_q == S_DIV_F) || (state_q == S_RED_N) || (state_q == S_RED_D);

	always_comb begin
		case (state_q)
			S_MFI: begin
				sub_x = rem_q;
				sub_y = {{(SUB_W - REF_W){1'b0}}, ref_q};
			end
			S_DIV_F, S_RED_N, S_RED_D: begin
				sub_x = {rem_q[SUB_W-2:0], dq_q[FRAC_W-1]};
				sub_y = {{(SUB_W - REF_W){1'b0}}, div_q};
			end
			S_GCD: begin
				sub_x = {{(SUB_W - FRAC_W){1'b0}}, gcd_swap ? gb_q : ga_q};
				sub_y = {{(SUB_W - FRAC_W){1'b0}}, gcd_swap ? ga_q : gb_q};
			end
			default: begin
				sub_x = '0;
				sub_y = '0;
			end
		endcase
	end

	// Range bounds: the target lies below ref*8/PD_LIMIT rounded down exactly
	// when (target+1)*PD_LIMIT does not exceed ref*8; the top is 4*MFI_LIMIT*ref.
	assign ref_x8    = LO_W'({ref_q, 3'b000});
	assign tgt_lo    = (LO_W'(tgt_q) + LO_W'(1)) * LO_W'(PD_LIMIT);
	assign hi_val    = {{(HI_W - REF_W){1'b0}}, ref_q} * HI_W'(HI_MUL);
	assign range_bad = (tgt_lo <= ref_x8) || (CMP_W'(tgt_q) > CMP_W'(hi_val));

	// Quarter of target*pd, and the scaled remainder product.
	assign a_val = acc_q[ACC_W-1:2];
	assign prod  = {{FRAC_W{1'b0}}, rem_q[REF_W-1:0]} * {{REF_W{1'b0}}, mfd_q};

	// Quotient register after the current restoring division step.
	assign quot = {dq_q[FRAC_W-2:0], ~sub_borrow};

	// Next state and datapath.
	always_comb begin
		state_d  = state_q;
		ref_d    = ref_q;
		tgt_d    = tgt_q;
		pd_d     = pd_q;
		acc_d    = acc_q;
		mfi_d    = mfi_q;
		rem_d    = rem_q;
		dq_d     = dq_q;
		div_d    = div_q;
		cnt_d    = cnt_q;
		mfd_d    = mfd_q;
		mfn_d    = mfn_q;
		ga_d     = ga_q;
		gb_d     = gb_q;
		lim_hi_d = lim_hi_q;
		lim_lo_d = lim_lo_q;
		res_d    = res_q;
		idle     = 1'b0;
		res_valid = 1'b0;

		case (state_q)
			S_IDLE: begin
				idle = 1'b1;
				if (start) begin
					ref_d   = ref_hz;
					tgt_d   = target_hz;
					state_d = S_CHECK;
				end
			end

			// Reject bad requests, then prepare the predivider search.
			S_CHECK: begin
				mfd_d    = table_denominator;
				acc_d    = ACC_W'(tgt_q);
				pd_d     = PD_W'(1);
				mfi_d    = '0;
				lim_hi_d = {{MFI_W{1'b0}}, ref_q} * SUB_W'(MFI_LIMIT + 1);
				lim_lo_d = {{MFI_W{1'b0}}, ref_q} * SUB_W'(MFI_FLOOR);
				res_d    = '0;
				if (range_bad) begin
					res_d.status = ST_RANGE;
					state_d      = S_DONE;
				end else if ((ref_q == '0) || (ref_q != table_ref_hz)) begin
					res_d.status = ST_UNKNOWN_REF;
					state_d      = S_DONE;
				end else begin
					state_d = S_SEARCH;
				end
			end

			// One predivider per cycle; stop at the first usable factor.
			S_SEARCH: begin
				res_d = '0;
				if (a_val >= {{(A_W - SUB_W){1'b0}}, lim_hi_q}) begin
					res_d.status = ST_TOO_LARGE;
					state_d      = S_DONE;
				end else if (a_val >= {{(A_W - SUB_W){1'b0}}, lim_lo_q}) begin
					rem_d   = SUB_W'(a_val);
					state_d = S_MFI;
				end else if (pd_q == PD_W'(PD_LIMIT)) begin
					res_d.status = ST_NO_PD;
					state_d      = S_DONE;
				end else begin
					pd_d  = pd_q + PD_W'(1);
					acc_d = acc_q + ACC_W'(tgt_q);
				end
			end

			// Integer factor by repeated subtraction of ref; the rest stays in rem.
			S_MFI: begin
				if (!sub_borrow) begin
					rem_d = sub_diff[SUB_W-1:0];
					mfi_d = mfi_q + MFI_W'(1);
				end else begin
					state_d = S_MUL;
				end
			end

			// Scale the rest by the denominator and set up the division by ref.
			S_MUL: begin
				rem_d   = {{(SUB_W - REF_W){1'b0}}, prod[PROD_W-1:FRAC_W]};
				dq_d    = prod[FRAC_W-1:0];
				div_d   = ref_q;
				cnt_d   = CNT_W'(FRAC_W - 1);
				state_d = S_DIV_F;
			end

			// Restoring division steps shared by the three divisions.
			S_DIV_F, S_RED_N, S_RED_D: begin
				rem_d = sub_borrow ? sub_x : sub_diff[SUB_W-1:0];
				dq_d  = quot;
				cnt_d = cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					cnt_d = CNT_W'(FRAC_W - 1);
					rem_d = '0;
					case (state_q)
						S_DIV_F: begin
							if (quot == '0) begin
								res_d.status           = ST_OK;
								res_d.prediv           = PREDIV_W'(pd_q);
								res_d.int_factor       = INT_W'(mfi_q);
								res_d.frac_numerator   = '0;
								res_d.frac_denominator = mfd_q;
								state_d                = S_DONE;
							end else begin
								mfn_d   = quot;
								ga_d    = mfd_q;
								gb_d    = quot;
								state_d = S_GCD;
							end
						end
						S_RED_N: begin
							mfn_d   = quot;
							dq_d    = mfd_q;
							state_d = S_RED_D;
						end
						default: begin
							res_d.status           = ST_OK;
							res_d.prediv           = PREDIV_W'(pd_q);
							res_d.int_factor       = INT_W'(mfi_q);
							res_d.frac_numerator   = mfn_q;
							res_d.frac_denominator = quot;
							state_d                = S_DONE;
						end
					endcase
				end
			end

			// Subtraction GCD; when a reaches zero, b holds the divisor.
			S_GCD: begin
				if (ga_q == '0) begin
					rem_d   = '0;
					dq_d    = mfn_q;
					div_d   = {{(REF_W - FRAC_W){1'b0}}, gb_q};
					cnt_d   = CNT_W'(FRAC_W - 1);
					state_d = S_RED_N;
				end else begin
					ga_d = sub_diff[FRAC_W-1:0];
					if (gcd_swap) begin
						gb_d = ga_q;
					end
				end
			end

			S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		ref_q    <= ref_d;
		tgt_q    <= tgt_d;
		pd_q     <= pd_d;
		acc_q    <= acc_d;
		mfi_q    <= mfi_d;
		rem_q    <= rem_d;
		dq_q     <= dq_d;
		div_q    <= div_d;
		cnt_q    <= cnt_d;
		mfd_q    <= mfd_d;
		mfn_q    <= mfn_d;
		ga_q     <= ga_d;
		gb_q     <= gb_d;
		lim_hi_q <= lim_hi_d;
		lim_lo_q <= lim_lo_d;
		res_q    <= res_d;
	end

	assign res = res_q;

	// A good result carries a factor and predivider inside their limits.
	`PFPS_ASSERT_IMP(a_ok_limits, clk, arst_n, (state_q == S_DONE) && (res_q.status == ST_OK), (res_q.int_factor >= INT_W'(MFI_FLOOR)) && (res_q.int_factor <= INT_W'(MFI_LIMIT)) && (res_q.prediv != '0) && (res_q.prediv <= PREDIV_W'(PD_LIMIT)))
	// An error result has all settings cleared.
	`PFPS_ASSERT_IMP(a_err_zero, clk, arst_n, (state_q == S_DONE) && (res_q.status != ST_OK), (res_q.prediv == '0) && (res_q.int_factor == '0) && (res_q.frac_numerator == '0) && (res_q.frac_denominator == '0))
	// The GCD never runs with a zero second operand.
	`PFPS_ASSERT_IMP(a_gcd_b_nonzero, clk, arst_n, state_q == S_GCD, gb_q != '0)
	// The partial remainder stays below the divisor, so no quotient bit is lost.
	`PFPS_ASSERT_IMP(a_div_rem, clk, arst_n, div_state, rem_q < {{(SUB_W - REF_W){1'b0}}, div_q})
	// A finished result holds until it is taken.
	`PFPS_ASSERT_NXT(a_done_hold, clk, arst_n, (state_q == S_DONE) && !res_ready, (state_q == S_DONE) && $stable(res_q))

endmodule

`default_nettype wire

[hw/rtl/pll_fractional_param_solver.sv]
// ----------------------------------------------------------------------------
// PLL fractional parameter solver
// Finds predivider, integer factor and reduced fraction for a fractional-N PLL.
// ----------------------------------------------------------------------------
// The solver takes one request transaction at a time and holds req.ready low
// until that request's result has moved into the output register. A request
// rejected by the range or reference check goes straight to the result
// hand-off. A solved request runs the check, the predivider search (one search
// step per value tried), the integer factor loop (one subtraction each, plus
// one step that ends the loop), the multiply, the 16-step division for the
// numerator, the subtraction GCD (one subtraction each, at most as many as the
// denominator value and so at most 65535, plus one step that ends it), the two
// 16-step reductions, the result hand-off and the return to idle. A zero
// numerator skips the GCD and the reduction. The integer factor, the divisions
// and the GCD run on a single shared subtractor. While a result waits in the
// output register, the next request can already be accepted and solved.
`default_nettype none

module pll_fractional_param_solver import pfps_pkg::*; #(
	parameter int unsigned PD_LIMIT  = PFPS_PD_LIMIT,
	parameter int unsigned MFI_LIMIT = PFPS_MFI_LIMIT
) (
	input  logic        clk,
	input  logic        arst_n,
	pfps_req_if.sink    req,
	pfps_rsp_if.source  rsp,
	pfps_cfg_if.sink    cfg
);

	logic [REF_W-1:0] table_ref_q;
	logic [DEN_W-1:0] table_den_q;
	logic             core_idle;
	logic             core_start;
	logic             core_res_valid;
	logic             core_res_ready;
	pfps_res_t        core_res;
	logic             out_valid_q;
	pfps_res_t        out_q;

	// Configuration registers; writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_ref_q <= RESET_TABLE_REF;
			table_den_q <= RESET_TABLE_DEN;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_IDX_TABLE_REF: table_ref_q <= cfg.data[REF_W-1:0];
				CFG_IDX_TABLE_DEN: table_den_q <= cfg.data[DEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Request side.
	assign req.ready  = core_idle;
	assign core_start = req.valid & core_idle;

	pfps_core #(
		.PD_LIMIT  (PD_LIMIT),
		.MFI_LIMIT (MFI_LIMIT)
	) u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (core_start),
		.ref_hz            (req.ref_hz),
		.target_hz         (req.target_hz),
		.table_ref_hz      (table_ref_q),
		.table_denominator (table_den_q),
		.idle              (core_idle),
		.res_valid         (core_res_valid),
		.res_ready         (core_res_ready),
		.res               (core_res)
	);

	// Output register: frees the core as soon as a result is moved here.
	assign core_res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_res_valid && core_res_ready) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_res_valid && core_res_ready) begin
			out_q <= core_res;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.status           = out_q.status;
	assign rsp.prediv           = out_q.prediv;
	assign rsp.int_factor       = out_q.int_factor;
	assign rsp.frac_numerator   = out_q.frac_numerator;
	assign rsp.frac_denominator = out_q.frac_denominator;

endmodule

`default_nettype wire
